// ----- hdl/dtcpwm_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, command codes and control struct for the dithered two-channel PWM.
package dtcpwm_pkg;

  localparam int PRECISION_BITS   = 4;
  localparam int COUNT_W          = 16;
  localparam int DUTY_W           = 16;
  localparam int REM_W            = (PRECISION_BITS > 0) ? PRECISION_BITS : 1;
  localparam logic [COUNT_W-1:0] PERIOD_TOP_RESET = 16'd511;
  localparam logic [DUTY_W-1:0]  KEEP_MASK =
      DUTY_W'((32'd1 << PRECISION_BITS) - 32'd1);

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_DUTY = 2'd1,
    CMD_DISABLE  = 2'd2
  } command_t;

  // Per-channel strobes, already qualified by the input beat.
  typedef struct packed {
    logic set_duty;
    logic disable_pin;
    logic wrap;
  } chan_ctrl_t;

endpackage

// ----- hdl/dtcpwm_chan.sv -----
`timescale 1ns / 1ps
// One PWM channel: duty word, dither accumulator, compare value and enable.
module dtcpwm_chan
  import dtcpwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  chan_ctrl_t         ctrl,
  input  logic [DUTY_W-1:0]  duty,
  input  logic [COUNT_W-1:0] count_next,
  output logic               pin_next
);

  logic [DUTY_W-1:0]  fine_duty;
  logic [REM_W-1:0]   dither_remainder;
  logic [COUNT_W-1:0] compare_value;
  logic               output_enable;

  logic [DUTY_W-1:0]  acc;
  logic [COUNT_W-1:0] compare_value_next;
  logic [REM_W-1:0]   dither_remainder_next;
  logic               output_enable_next;

  // 16-bit accumulator wraps; high part becomes the compare, low part is carried.
  assign acc = DUTY_W'(DUTY_W'(dither_remainder) + fine_duty);

  always_comb begin
    compare_value_next    = compare_value;
    dither_remainder_next = dither_remainder;
    if (ctrl.wrap) begin
      compare_value_next    = COUNT_W'(acc >> PRECISION_BITS);
      dither_remainder_next = REM_W'(acc & KEEP_MASK);
    end
    output_enable_next = output_enable;
    if (ctrl.set_duty) begin
      output_enable_next = 1'b1;
    end else if (ctrl.disable_pin) begin
      output_enable_next = 1'b0;
    end
  end

  assign pin_next = output_enable_next && (count_next < compare_value_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      fine_duty        <= '0;
      dither_remainder <= '0;
      compare_value    <= '0;
      output_enable    <= 1'b0;
    end else begin
      if (ctrl.set_duty) begin
        fine_duty <= duty;
      end
      dither_remainder <= dither_remainder_next;
      compare_value    <= compare_value_next;
      output_enable    <= output_enable_next;
    end
  end

endmodule

// ----- hdl/dithered_two_channel_pwm.sv -----
`timescale 1ns / 1ps
// Top level of the dithered two-channel fast-PWM generator.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_valid/cfg_ready  period_top
//   in        in         in_valid/in_stall    command, channel, duty
//   out       out        out_valid/out_stall  pin_a, pin_b, count_now, period_wrapped
//
// One beat in per cycle while in_stall is low; the output register takes its result.
// Counter, dither and compare update in a single pass of logic at the input beat.
// rst (synchronous) clears counter, duties, remainders, compares, enables; top = 511.
// in_stall rises only while a result sits in the output register and out is stalled.
// cfg_ready is always high.
module dithered_two_channel_pwm
  import dtcpwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] period_top,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic               channel,
  input  logic [DUTY_W-1:0]  duty,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pin_a,
  output logic               pin_b,
  output logic [COUNT_W-1:0] count_now,
  output logic               period_wrapped
);

  logic [COUNT_W-1:0] top;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               in_accept;
  logic               wrap;
  logic               set_duty;
  logic               disable_pin;
  chan_ctrl_t         ctrl_a;
  chan_ctrl_t         ctrl_b;
  logic               pin_a_next;
  logic               pin_b_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    wrap        = 1'b0;
    set_duty    = 1'b0;
    disable_pin = 1'b0;
    count_next  = count;
    case (command)
      CMD_TICK: begin
        if (count >= top) begin
          wrap       = in_accept;
          count_next = '0;
        end else begin
          count_next = COUNT_W'(count + 1'b1);
        end
      end
      CMD_SET_DUTY: set_duty    = in_accept;
      CMD_DISABLE:  disable_pin = in_accept;
      default: ;
    endcase
  end

  assign ctrl_a = '{set_duty: set_duty && !channel, disable_pin: disable_pin && !channel,
                    wrap: wrap};
  assign ctrl_b = '{set_duty: set_duty && channel, disable_pin: disable_pin && channel,
                    wrap: wrap};

  dtcpwm_chan u_chan_a (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl_a),
    .duty       (duty),
    .count_next (count_next),
    .pin_next   (pin_a_next)
  );

  dtcpwm_chan u_chan_b (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl_b),
    .duty       (duty),
    .count_next (count_next),
    .pin_next   (pin_b_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top       <= PERIOD_TOP_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        top <= period_top;
      end
      if (in_accept) begin
        count <= count_next;
      end
      // Hold the result while stalled; drop valid once taken with nothing new.
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pin_a          <= pin_a_next;
      pin_b          <= pin_b_next;
      count_now      <= count_next;
      period_wrapped <= wrap;
    end
  end

`ifndef SYNTH
  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && period_wrapped |-> count_now == '0)
    else $error("wrapped beat with nonzero count");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_non_tick_holds: assert property (@(posedge clk) disable iff (rst)
    in_accept && command != CMD_TICK |=> count == $past(count))
    else $error("counter moved on a non-tick beat");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    in_accept && command == CMD_TICK && count < top |=>
      count == COUNT_W'($past(count) + 1'b1))
    else $error("tick below top did not advance counter");

  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> count_now == count)
    else $error("reported count differs from counter");
`endif

endmodule

// ----- tb/tb_dithered_two_channel_pwm.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the dithered two-channel PWM: directed and random command streams.
module tb_dithered_two_channel_pwm;
  import dtcpwm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic               pin_a;
    logic               pin_b;
    logic [COUNT_W-1:0] count;
    logic               wrapped;
  } pwm_levels_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_top = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         command = CMD_TICK;
  logic               channel = 1'b0;
  logic [DUTY_W-1:0]  duty = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               pin_a;
  logic               pin_b;
  logic [COUNT_W-1:0] count_now;
  logic               period_wrapped;

  // Predicted timer state
  logic [COUNT_W-1:0] pred_top;
  logic [COUNT_W-1:0] pred_count;
  logic [DUTY_W-1:0]  pred_fine [2];
  logic [DUTY_W-1:0]  pred_rem [2];
  logic [COUNT_W-1:0] pred_cmp [2];
  logic               pred_en [2];

  pwm_levels_t pending_levels [$];
  int          errors = 0;
  int          burst_left = 0;
  logic [7:0]  stall_step = '0;

  dithered_two_channel_pwm i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .period_top     (cfg_top),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .channel        (channel),
    .duty           (duty),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pin_a          (pin_a),
    .pin_b          (pin_b),
    .count_now      (count_now),
    .period_wrapped (period_wrapped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: quiet, random, periodic and heavy stall stretches in turn
  always @(posedge clk) begin
    stall_step <= stall_step + 1'b1;
    case (stall_step[7:6])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 2) == 0);
      2'd2: out_stall <= (stall_step[2:0] >= 3'd5);
      default: out_stall <= ($urandom_range(0, 9) < 6);
    endcase
  end

  task automatic step_pwm(input logic [1:0] cmd, input logic ch, input logic [DUTY_W-1:0] dw);
    pwm_levels_t       lv;
    logic [DUTY_W-1:0] acc;
    lv.wrapped = 1'b0;
    if (cmd == CMD_TICK) begin
      if (pred_count >= pred_top) begin
        pred_count = '0;
        lv.wrapped = 1'b1;
        // accumulator wraps at 16 bits; keep only the fraction as remainder
        for (int c = 0; c < 2; c++) begin
          acc = pred_rem[c] + pred_fine[c];
          pred_cmp[c] = acc >> PRECISION_BITS;
          pred_rem[c] = acc & KEEP_MASK;
        end
      end else begin
        pred_count = pred_count + 1'b1;
      end
    end else if (cmd == CMD_SET_DUTY) begin
      pred_fine[ch] = dw;
      pred_en[ch] = 1'b1;
    end else if (cmd == CMD_DISABLE) begin
      pred_en[ch] = 1'b0;
    end
    lv.pin_a = pred_en[0] && (pred_count < pred_cmp[0]);
    lv.pin_b = pred_en[1] && (pred_count < pred_cmp[1]);
    lv.count = pred_count;
    pending_levels.push_back(lv);
  endtask

  task automatic check_level(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    pwm_levels_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual count %0d", $time, count_now);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        check_level("pin_a", want.pin_a, pin_a);
        check_level("pin_b", want.pin_b, pin_b);
        check_level("count_now", want.count, count_now);
        check_level("period_wrapped", want.wrapped, period_wrapped);
      end
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic ch, input logic [DUTY_W-1:0] dw);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    channel  <= ch;
    duty     <= dw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_pwm(cmd, ch, dw);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  // Drop valid and wait until every result is out
  task automatic settle_outputs;
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_top(input logic [COUNT_W-1:0] top);
    settle_outputs();
    cfg_valid <= 1'b1;
    cfg_top   <= top;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred_top = top;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_ignored_fields;
    send_beat(CMD_UNUSED, 1'b1, 16'hFFFF);
    send_beat(CMD_TICK, 1'b1, 16'hFFFF);
    send_beat(CMD_DISABLE, 1'b1, 16'hFFFF);
    send_beat(CMD_SET_DUTY, 1'b0, 16'hFFFF);
    send_beat(CMD_SET_DUTY, 1'b1, 16'h0000);
    send_beat(CMD_TICK, 1'b0, 16'h0000);
  endtask

  // Every tick wraps; channel B has a compare of zero
  task automatic test_top_zero;
    write_top('0);
    repeat (3) send_beat(CMD_TICK, 1'($urandom), 16'($urandom));
    send_beat(CMD_DISABLE, 1'b0, 16'h0000);
  endtask

  // A duty of 1.5 steps alternates the compare between 1 and 2
  task automatic test_dither_steps;
    write_top(16'd3);
    send_beat(CMD_SET_DUTY, 1'b0, 16'd24);
    repeat (8) send_beat(CMD_TICK, 1'b0, 16'h0000);
  endtask

  task automatic test_top_lowered;
    write_top(16'hFFFF);
    repeat (4) send_beat(CMD_TICK, 1'b1, 16'h0000);
    write_top(16'd1);
    repeat (2) send_beat(CMD_TICK, 1'b0, 16'h0000);
  endtask

  task automatic test_random_traffic;
    int               top;
    int               span;
    int               pick;
    logic [1:0]       cmd;
    logic [DUTY_W-1:0] dw;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       top = 65535;
        1:       top = 0;
        2:       top = 1;
        3:       top = 5;
        4:       top = 300;
        5:       top = 2;
        9:       top = 15;
        11:      top = 9;
        default: top = $urandom_range(2, 40);
      endcase
      write_top(COUNT_W'(top));
      span = (top + 2) * 16;
      if (span > 65535) span = 65535;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      cmd = CMD_TICK;
        else if (pick < 85) cmd = CMD_SET_DUTY;
        else if (pick < 95) cmd = CMD_DISABLE;
        else                cmd = CMD_UNUSED;
        // keep most duties near the period so pins actually toggle
        if (cmd == CMD_SET_DUTY && $urandom_range(0, 7) != 0) dw = DUTY_W'($urandom_range(0, span));
        else dw = DUTY_W'($urandom);
        send_beat(cmd, 1'($urandom), dw);
      end
    end
  endtask

  initial begin
    pred_top   = PERIOD_TOP_RESET;
    pred_count = '0;
    for (int c = 0; c < 2; c++) begin
      pred_fine[c] = '0;
      pred_rem[c]  = '0;
      pred_cmp[c]  = '0;
      pred_en[c]   = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_ignored_fields();
    test_top_zero();
    test_dither_steps();
    test_top_lowered();
    test_random_traffic();
    settle_outputs();
    if (errors == 0) begin
      $display("tb_dithered_two_channel_pwm: clean");
    end else begin
      $display("tb_dithered_two_channel_pwm: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_dithered_two_channel_pwm: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dtcpwm_pkg.sv
hdl/dtcpwm_chan.sv
hdl/dithered_two_channel_pwm.sv
tb/tb_dithered_two_channel_pwm.sv
